>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, quiet while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/slati_pkg.sv
// ---------------------------------------------------------------------------
// slati_pkg
// Shared codes, character constants, helpers and controller/datapath links.
// ---------------------------------------------------------------------------
package slati_pkg;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_RESYNC = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_CONN  = 2'd1;
    localparam logic [1:0] KIND_LOST  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd50;
    localparam logic [15:0] IDLE_TICKS_MAX   = 16'hFFFF;
    localparam int          PREFIX_LEN       = 7;

    // Lower-case an ASCII letter, leave everything else alone.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    // "ok+conn", folded
    function automatic logic [7:0] pat_conn(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h6F;
            3'd1:    c = 8'h6B;
            3'd2:    c = 8'h2B;
            3'd3:    c = 8'h63;
            3'd4:    c = 8'h6F;
            3'd5:    c = 8'h6E;
            3'd6:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "ok+lost", folded
    function automatic logic [7:0] pat_lost(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h6F;
            3'd1:    c = 8'h6B;
            3'd2:    c = 8'h2B;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6F;
            3'd5:    c = 8'h73;
            3'd6:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "ok", folded
    function automatic logic [7:0] pat_ok(input logic k);
        return k ? 8'h6B : 8'h6F;
    endfunction

    typedef struct packed {
        logic take_item;   // input beat accepted this cycle
        logic rd_end;      // read entry end-1
        logic end_dec;     // drop one trailing character
        logic rd_first;    // read entry first
        logic first_inc;   // drop one leading character
        logic match_init;  // clear index, arm prefix flags
        logic rd_fk;       // read entry first+index
        logic match_step;  // compare read byte with prefixes, advance index
        logic match_short; // line ended before the prefixes
        logic emit_init;   // clear index for emission
        logic out_load;    // load output register, advance index
    } slati_cmd_t;

    typedef struct packed {
        logic emit_start;   // pending input beat ends a line
        logic end_zero;
        logic strip;        // read byte is trailing whitespace
        logic first_eq_end;
        logic blank;        // read byte is space or tab
        logic k_lt_len;
        logic k_at_prefix;
        logic last_k;
        logic out_free;
    } slati_sts_t;

endpackage

>>> src/serial_line_assembler_trim_idle_unit.sv
// ---------------------------------------------------------------------------
// serial_line_assembler_trim_idle_unit
// Assembles received serial bytes into lines, trims and classifies them.
// ---------------------------------------------------------------------------
// Input stream: one beat per event. tuser selects the kind (received byte,
// millisecond tick, receive-error resync), tdata carries the byte.
// Output stream: one beat per byte of a trimmed line; tlast marks the final
// byte, tdata also carries the line length, tuser the line kind from a
// case-insensitive prefix check (connect, lost, ack, other).
// Configuration: cfg_we/cfg_wdata load the idle limit in ticks (reset 50);
// write it only while the block is idle.
// Input handshake: a beat that does not end a line leaves s_tready high. A
// beat that ends a line holds s_tready low while the line store is walked
// through its single registered read port: trailing blanks are dropped one
// by one, then leading blanks, then the first bytes, at most seven, are
// compared with the prefixes, then each kept byte is read and loaded into
// the output register. A blank line is dropped and yields no beat.
// Reset clears the pending line, the overflow mark, the tick count and the
// output valid flag; the line store needs no clearing.
// A stalled receiver holds the current output beat and pauses emission; the
// input side stays stalled until the last byte has been loaded.
// ---------------------------------------------------------------------------
module serial_line_assembler_trim_idle_unit
    import slati_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] line_byte, [14:8] line_length, [15] zero
    output logic        m_tlast,   // last_of_line
    output logic [1:0]  m_tuser    // [1:0] line_kind
);

    slati_cmd_t cmd;
    slati_sts_t sts;
    logic [7:0] line_byte;
    logic [6:0] line_length;

    // Sequencer: owns the handshake on the input side and every step order.
    slati_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: line store, counters and the output beat register.
    slati_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (s_tuser),
        .byte_value   (s_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .line_byte    (line_byte),
        .last_of_line (m_tlast),
        .line_length  (line_length),
        .line_kind    (m_tuser)
    );

    // Pack the output beat, byte in the low bits.
    assign m_tdata = {1'b0, line_length, line_byte};

endmodule

>>> src/slati_ctrl.sv
// ---------------------------------------------------------------------------
// slati_ctrl
// Sequencer for intake, trimming, prefix match and line emission.
// ---------------------------------------------------------------------------
module slati_ctrl
    import slati_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  slati_sts_t sts,
    output slati_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TE_RD,
        ST_TE_CHK,
        ST_TS_RD,
        ST_TS_CHK,
        ST_MT_RD,
        ST_MT_CHK,
        ST_EM_RD,
        ST_EM_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rdy_reg;

    assign s_tready = rdy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item = s_tvalid && rdy_reg;
                if (cmd.take_item && sts.emit_start)
                    state_next = ST_TE_RD;
            end
            ST_TE_RD:
            begin
                if (sts.end_zero)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.rd_end = 1'b1;
                    state_next = ST_TE_CHK;
                end
            end
            ST_TE_CHK:
            begin
                if (sts.strip)
                begin
                    cmd.end_dec = 1'b1;
                    state_next  = ST_TE_RD;
                end
                else
                    state_next = ST_TS_RD;
            end
            ST_TS_RD:
            begin
                if (sts.first_eq_end)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_TS_CHK;
                end
            end
            ST_TS_CHK:
            begin
                if (sts.blank)
                begin
                    cmd.first_inc = 1'b1;
                    state_next    = ST_TS_RD;
                end
                else
                begin
                    cmd.match_init = 1'b1;
                    state_next     = ST_MT_RD;
                end
            end
            ST_MT_RD:
            begin
                if (sts.k_at_prefix)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EM_RD;
                end
                else if (sts.k_lt_len)
                begin
                    cmd.rd_fk  = 1'b1;
                    state_next = ST_MT_CHK;
                end
                else
                begin
                    cmd.match_short = 1'b1;
                    cmd.emit_init   = 1'b1;
                    state_next      = ST_EM_RD;
                end
            end
            ST_MT_CHK:
            begin
                cmd.match_step = 1'b1;
                state_next     = ST_MT_RD;
            end
            ST_EM_RD:
            begin
                cmd.rd_fk  = 1'b1;
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.last_k ? ST_IDLE : ST_EM_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rdy_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            rdy_reg   <= (state_next == ST_IDLE);
        end
    end

endmodule

>>> src/slati_dp.sv
// ---------------------------------------------------------------------------
// slati_dp
// Line store, counters, prefix flags and output register.
// ---------------------------------------------------------------------------
module slati_dp
    import slati_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic [1:0]  req_type,
    input  logic [7:0]  byte_value,
    input  slati_cmd_t  cmd,
    output slati_sts_t  sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  line_byte,
    output logic        last_of_line,
    output logic [6:0]  line_length,
    output logic [1:0]  line_kind
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    logic [CNT_W-1:0] pend_reg;
    logic             ovf_reg;
    logic [15:0]      idle_reg;
    logic [15:0]      limit_reg;
    logic [CNT_W-1:0] end_reg;
    logic [CNT_W-1:0] first_reg;
    logic [CNT_W-1:0] k_reg;
    logic             conn_reg;
    logic             lost_reg;
    logic             ok_reg;

    logic             vld_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [6:0]       len_reg;
    logic [1:0]       kind_reg;

    logic [15:0]      idle_inc;
    logic             is_term;
    logic [CNT_W-1:0] end_m1;
    logic [CNT_W-1:0] first_k;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] k_p1;
    logic [7:0]       rd_fold;
    logic [1:0]       kind;

    assign idle_inc = (idle_reg == IDLE_TICKS_MAX) ? idle_reg : idle_reg + 16'd1;
    assign is_term  = (byte_value == CH_CR) || (byte_value == CH_LF);
    assign end_m1   = end_reg - CNT_W'(1);
    assign first_k  = first_reg + k_reg;
    assign len      = end_reg - first_reg;
    assign k_p1     = k_reg + CNT_W'(1);
    assign rd_fold  = fold_case(rd_data_reg);

    always_comb
    begin
        if (conn_reg)
            kind = KIND_CONN;
        else if (lost_reg)
            kind = KIND_LOST;
        else if (ok_reg)
            kind = KIND_ACK;
        else
            kind = KIND_OTHER;
    end

    always_comb
    begin
        sts.emit_start = ((req_type == REQ_BYTE) && is_term && !ovf_reg &&
                          (pend_reg != '0)) ||
                         ((req_type == REQ_TICK) && (pend_reg != '0) &&
                          (idle_inc >= limit_reg));
        sts.end_zero     = (end_reg == '0);
        sts.blank        = (rd_data_reg == CH_SPACE) || (rd_data_reg == CH_TAB);
        sts.strip        = sts.blank || (rd_data_reg == CH_CR) || (rd_data_reg == CH_LF);
        sts.first_eq_end = (first_reg == end_reg);
        sts.k_lt_len     = (k_reg < len);
        sts.k_at_prefix  = (k_reg == CNT_W'(PREFIX_LEN));
        sts.last_k       = (k_p1 == len);
        sts.out_free     = !vld_reg || m_tready;
    end

    // Single read port, address picked by the current sequencer step.
    always_comb
    begin
        rd_en   = cmd.rd_end || cmd.rd_first || cmd.rd_fk;
        rd_addr = first_k[IDX_W-1:0];
        if (cmd.rd_end)
            rd_addr = end_m1[IDX_W-1:0];
        else if (cmd.rd_first)
            rd_addr = first_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item && (req_type == REQ_BYTE) && !is_term && !ovf_reg &&
            (pend_reg < CNT_W'(STORE_DEPTH)))
            mem[pend_reg[IDX_W-1:0]] <= byte_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            ovf_reg   <= 1'b0;
            idle_reg  <= '0;
            limit_reg <= IDLE_LIMIT_RESET;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.take_item)
            begin
                case (req_type)
                    REQ_BYTE:
                    begin
                        idle_reg <= '0;
                        if (is_term)
                        begin
                            ovf_reg  <= 1'b0;
                            pend_reg <= '0;
                        end
                        else if (!ovf_reg)
                        begin
                            if (pend_reg < CNT_W'(STORE_DEPTH))
                                pend_reg <= pend_reg + CNT_W'(1);
                            else
                            begin
                                ovf_reg  <= 1'b1;
                                pend_reg <= '0;
                            end
                        end
                    end
                    REQ_TICK:
                    begin
                        idle_reg <= idle_inc;
                        if (sts.emit_start)
                            pend_reg <= '0;
                    end
                    REQ_RESYNC:
                    begin
                        pend_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.out_load)
                vld_reg <= 1'b1;
            else if (m_tready)
                vld_reg <= 1'b0;
        end
    end

    // Working registers of the trim, match and emit steps.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && sts.emit_start)
        begin
            end_reg   <= pend_reg;
            first_reg <= '0;
        end
        if (cmd.end_dec)
            end_reg <= end_m1;
        if (cmd.first_inc)
            first_reg <= first_reg + CNT_W'(1);
        if (cmd.match_init)
        begin
            k_reg    <= '0;
            conn_reg <= 1'b1;
            lost_reg <= 1'b1;
            ok_reg   <= 1'b1;
        end
        if (cmd.match_step)
        begin
            k_reg <= k_p1;
            if (rd_fold != pat_conn(k_reg[2:0]))
                conn_reg <= 1'b0;
            if (rd_fold != pat_lost(k_reg[2:0]))
                lost_reg <= 1'b0;
            if ((k_reg < CNT_W'(2)) && (rd_fold != pat_ok(k_reg[0])))
                ok_reg <= 1'b0;
        end
        if (cmd.match_short)
        begin
            conn_reg <= 1'b0;
            lost_reg <= 1'b0;
            if (k_reg < CNT_W'(2))
                ok_reg <= 1'b0;
        end
        if (cmd.emit_init)
            k_reg <= '0;
        if (cmd.out_load)
        begin
            k_reg    <= k_p1;
            byte_reg <= rd_data_reg;
            last_reg <= sts.last_k;
            len_reg  <= 7'(len);
            kind_reg <= kind;
        end
    end

    assign m_tvalid     = vld_reg;
    assign line_byte    = byte_reg;
    assign last_of_line = last_reg;
    assign line_length  = len_reg;
    assign line_kind    = kind_reg;

endmodule

>>> src/slati_checker.sv
// ---------------------------------------------------------------------------
// slati_checker
// Port-level checks for the line assembler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slati_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    logic [18:0] beat;

    assign beat = {m_tuser, m_tlast, m_tdata};

    // Mid-line beat on the output: input side must be held off.
    `ASSERT_NEVER(a_no_intake_mid_line, clk, rst_n, m_tvalid && !m_tlast && s_tready)

    // A presented beat carries fully defined fields.
    `ASSERT_NEVER(a_beat_known, clk, rst_n, m_tvalid && $isunknown(beat))

    // Stalled output beat holds.
    `ASSERT_CLK(a_hold_on_stall, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(beat))

endmodule

bind serial_line_assembler_trim_idle_unit slati_checker u_slati_checker (.*);

>>> dv/line_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_stream_checker
// Watches the event, configuration and line streams of the line assembler,
// keeps its own copy of the line store and idle counter, predicts each
// trimmed and classified line and compares every output beat against it.
// ---------------------------------------------------------------------------
module line_stream_checker
    import slati_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] line_byte, [14:8] line_length, [15] zero
    input  logic        m_tlast,   // last_of_line
    input  logic [1:0]  m_tuser,   // [1:0] line_kind
    output int          fail_count,
    output int          backlog
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [6:0] len;
        logic [1:0] kind;
    } line_beat_t;

    line_beat_t  line_beats_due[$];
    logic [7:0]  line_buf [STORE_DEPTH];
    int          held_count;
    logic        overflowed;
    logic [15:0] idle_count;
    logic [15:0] idle_limit;
    int          errors;

    function automatic logic [7:0] lower_letter(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'h20;
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic starts_with(input int start, input int len, input string pat);
        int k;
        for (k = 0; k < pat.len(); k++)
        begin
            if (k >= len)
                return 1'b0;
            if (lower_letter(line_buf[start + k]) != lower_letter(pat[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%0t: %s", $time, msg);
    endtask

    // Trim the held line and queue one beat per remaining byte.
    task automatic emit_trimmed_line();
        int         stop;
        int         start;
        int         len;
        int         k;
        logic [1:0] kind;
        line_beat_t beat;
        stop = (held_count > STORE_DEPTH) ? STORE_DEPTH : held_count;
        start = 0;
        held_count = 0;
        while (stop > 0 && (is_blank(line_buf[stop - 1]) || line_buf[stop - 1] == CH_CR ||
                            line_buf[stop - 1] == CH_LF))
            stop--;
        while (start < stop && is_blank(line_buf[start]))
            start++;
        if (start == stop)
            return;
        len = stop - start;
        if (starts_with(start, len, "ok+conn"))
            kind = KIND_CONN;
        else if (starts_with(start, len, "ok+lost"))
            kind = KIND_LOST;
        else if (starts_with(start, len, "ok"))
            kind = KIND_ACK;
        else
            kind = KIND_OTHER;
        for (k = 0; k < len; k++)
        begin
            beat.ch   = line_buf[start + k];
            beat.last = (k + 1 == len);
            beat.len  = 7'(len);
            beat.kind = kind;
            line_beats_due.push_back(beat);
        end
    endtask

    task automatic absorb_event(input logic [1:0] req, input logic [7:0] c);
        if (req == REQ_BYTE)
        begin
            idle_count = '0;
            if (c == CH_CR || c == CH_LF)
            begin
                if (overflowed)
                begin
                    overflowed = 1'b0;
                    held_count = 0;
                end
                else if (held_count != 0)
                    emit_trimmed_line();
            end
            else if (!overflowed)
            begin
                if (held_count < STORE_DEPTH)
                begin
                    line_buf[held_count] = c;
                    held_count++;
                end
                else
                begin
                    overflowed = 1'b1;
                    held_count = 0;
                end
            end
        end
        else if (req == REQ_TICK)
        begin
            if (idle_count != IDLE_TICKS_MAX)
                idle_count++;
            if (held_count != 0 && idle_count >= idle_limit)
                emit_trimmed_line();
        end
        else if (req == REQ_RESYNC)
        begin
            held_count = 0;
            overflowed = 1'b0;
        end
    endtask

    task automatic check_line_beat();
        line_beat_t want;
        logic       ok;
        if (line_beats_due.size() == 0)
        begin
            note_failure($sformatf("unexpected beat: byte %02h len %0d kind %0d last %0b",
                                   m_tdata[7:0], m_tdata[14:8], m_tuser, m_tlast));
            return;
        end
        want = line_beats_due.pop_front();
        ok = (m_tdata[7:0] === want.ch) && (m_tdata[14:8] === want.len) &&
             (m_tdata[15] === 1'b0) && (m_tlast === want.last) && (m_tuser === want.kind);
        if (!ok)
            note_failure($sformatf(
                "beat mismatch: exp byte %02h len %0d kind %0d last %0b / %s",
                want.ch, want.len, want.kind, want.last,
                $sformatf("got byte %02h len %0d kind %0d last %0b pad %0b",
                          m_tdata[7:0], m_tdata[14:8], m_tuser, m_tlast, m_tdata[15])));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_beats_due.delete();
            held_count = 0;
            overflowed = 1'b0;
            idle_count = '0;
            idle_limit = IDLE_LIMIT_RESET;
            errors     = 0;
            fail_count <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_line_beat();
            if (cfg_we)
                idle_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                absorb_event(s_tuser, s_tdata);
            backlog    <= line_beats_due.size();
            fail_count <= errors;
        end
    end

endmodule

>>> dv/serial_line_assembler_trim_idle_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_line_assembler_trim_idle_unit_tb
// Drives received bytes, ticks and resync events into the line assembler,
// first a handful of hand-picked lines, then random lines of every shape
// under several idle limits, with random gaps on both streams. A checker
// beside the block predicts and compares every output beat.
// ---------------------------------------------------------------------------
module serial_line_assembler_trim_idle_unit_tb;
    import slati_pkg::*;

    localparam int STORE_DEPTH     = 64;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int PHASE_COUNT     = 6;
    // Worst walk of the store after a beat that yields nothing (blank line).
    localparam int SETTLE_CYCLES   = 2 * STORE_DEPTH + 48;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int IDLE_PERCENT    = 23;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int SHAPE_PICK     = 0;
    localparam int SHAPE_SHORT    = 1;
    localparam int SHAPE_FULL     = 2;
    localparam int SHAPE_OVERFLOW = 3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_value
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] line_byte, [14:8] line_length, [15] zero
    logic        m_tlast;   // last_of_line
    logic [1:0]  m_tuser;   // [1:0] line_kind

    int          fail_count;
    int          backlog;
    int          items_sent;
    int          cycle_count;
    logic        calm;
    logic [15:0] cur_limit;

    // Idle limits per random phase; extremes first, phase 4 draws its own.
    logic [15:0] phase_limit [PHASE_COUNT] = '{16'hFFFF, 16'd0, 16'd2, 16'd1, 16'd9, 16'd5};

    always #6 clk = ~clk;

    serial_line_assembler_trim_idle_unit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    line_stream_checker #(
        .STORE_DEPTH (STORE_DEPTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    // Stall the line stream at random, except during the calm phase.
    always @(posedge clk)
    begin
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one event beat and hold it until the block takes it. Valid
    // stays high on return, so back-to-back beats never toggle it.
    task automatic send_beat(input logic [1:0] req, input logic [7:0] value);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic send_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++)
            send_beat(REQ_BYTE, text[k]);
    endtask

    // The tick beat carries random data, which the block must ignore.
    task automatic send_ticks(input int count);
        repeat (count) send_beat(REQ_TICK, 8'($urandom_range(255)));
    endtask

    // Drop valid, drain every predicted beat, then let any silent store walk
    // (a blank line) finish.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_idle_limit(input logic [15:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_limit = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One line of random content: optional blanks around a likely prefix
    // and a random body, closed by CR, LF, CRLF, idle timeout or resync.
    task automatic random_line(input int forced);
        int    shape;
        int    total;
        int    pick;
        int    ending;
        string head;
        shape = forced;
        if (shape == SHAPE_PICK)
        begin
            pick  = $urandom_range(99);
            shape = (pick < 4) ? SHAPE_OVERFLOW : (pick < 8) ? SHAPE_FULL : SHAPE_SHORT;
        end
        case ($urandom_range(5))
            0:       head = "OK+CONN";
            1:       head = "ok+Lost";
            2:       head = "OK+Set";
            3:       head = "Ok";
            4:       head = "OK+CONx";
            default: head = "";
        endcase
        if (shape == SHAPE_SHORT)
        begin
            repeat ($urandom_range(2)) send_beat(REQ_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
            send_text(head);
            // Mostly printable body; now and then any byte, terminators included.
            repeat ($urandom_range(8))
                send_beat(REQ_BYTE, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                             : 8'($urandom_range(126, 33)));
            repeat ($urandom_range(2)) send_beat(REQ_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
        end
        else
        begin
            // Fill the store exactly, or run past it to force an overflow.
            total = (shape == SHAPE_FULL) ? STORE_DEPTH : STORE_DEPTH + $urandom_range(4, 1);
            send_text(head);
            repeat (total - head.len()) send_beat(REQ_BYTE, 8'($urandom_range(126, 33)));
        end
        ending = $urandom_range(9);
        if (ending >= 7 && ending <= 8 && cur_limit == 16'hFFFF)
            ending = 0;
        case (ending)
            0, 1, 2, 3: send_beat(REQ_BYTE, CH_CR);
            4, 5:       send_beat(REQ_BYTE, CH_LF);
            6:
            begin
                send_beat(REQ_BYTE, CH_CR);
                send_beat(REQ_BYTE, CH_LF);
            end
            7, 8:       send_ticks((cur_limit == 16'd0) ? 1 : int'(cur_limit));
            default:    send_beat(REQ_RESYNC, 8'($urandom_range(255)));
        endcase
    endtask

    initial
    begin
        int p;
        int target;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = REQ_BYTE;
        m_tready   = 1'b0;
        calm       = 1'b0;
        items_sent = 0;
        cycle_count = 0;
        cur_limit  = IDLE_LIMIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Leading tab and trailing space around a lost-link report, CR end.
        send_beat(REQ_BYTE, CH_TAB);
        send_text("OK+LOST ");
        send_beat(REQ_BYTE, CH_CR);
        // Terminator on an empty line: ignore it.
        send_beat(REQ_BYTE, CH_LF);
        // All-blank line: discard it.
        send_beat(REQ_BYTE, CH_SPACE);
        send_beat(REQ_BYTE, CH_CR);
        // Extreme byte values, then a resync drops them.
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_RESYNC, 8'h00);
        // Unused selector: ignored.
        send_beat(REQ_UNUSED, 8'hA5);
        // An idle limit of one tick closes a one-byte line and a lower-case connect.
        write_idle_limit(16'd1);
        send_text("Z");
        send_ticks(1);
        send_text("ok+conn");
        send_ticks(1);

        // Random phases, each under its own idle limit; phase 2 runs with
        // no gaps on either stream.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_idle_limit((p == 4) ? 16'($urandom_range(12, 1)) : phase_limit[p]);
            calm   = (p == 2);
            target = items_sent + ITEMS_PER_PHASE;
            if (p == 0)
            begin
                random_line(SHAPE_OVERFLOW);
                random_line(SHAPE_FULL);
            end
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 15)
                    send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
                random_line(SHAPE_PICK);
            end
        end

        wait_quiet();
        if (fail_count == 0 && backlog == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/slati_pkg.sv
src/slati_ctrl.sv
src/slati_dp.sv
src/serial_line_assembler_trim_idle_unit.sv
src/slati_checker.sv
dv/line_stream_checker.sv
dv/serial_line_assembler_trim_idle_unit_tb.sv
